### design/edmf_pkg.sv
// ----------------------------------------------------------------------------
// Echo distance median filter package
// Field widths, register indexes, register reset values and the
// fixed-point factor that converts echo width to distance.
// ----------------------------------------------------------------------------
package edmf_pkg;

	// Field widths
	localparam int WIDTH_W = 16;
	localparam int DIST_W  = 19;
	localparam int CNT_W   = 4;
	localparam int CFG_W   = 19;
	localparam int CFG_IDX_W = 3;

	// Width to distance: (width * 4496) >> 10, cm with 8 fraction bits
	localparam int DIST_MULT  = 4496;
	localparam int DIST_SHIFT = 10;
	localparam int PROD_W     = WIDTH_W + 13;

	// Register indexes
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_SAMPLE_COUNT = 3'd0,
		REG_MIN_DISTANCE = 3'd1,
		REG_MAX_DISTANCE = 3'd2,
		REG_TIMEOUT_US   = 3'd3
	} cfg_reg_t;

	// Register reset values
	localparam logic [CNT_W-1:0]   RST_SAMPLE_COUNT = 4'd5;
	localparam logic [DIST_W-1:0]  RST_MIN_DISTANCE = 19'd512;
	localparam logic [DIST_W-1:0]  RST_MAX_DISTANCE = 19'd102400;
	localparam logic [WIDTH_W-1:0] RST_TIMEOUT_US   = 16'd30000;

endpackage

### design/echo_distance_median_filter_top.sv
// Input stage, then result register: a ping accepted into the input stage moves on once the
// result register is free, and the reading that the ping closes is registered there.
// Throughput: one ping per cycle while readings are taken; a parallel compare-and-shift
// insertion takes a ping in one pass, and a reading held by the receiver stalls the input.
// Reset: clears the round counters and valid flags and loads the register defaults;
// the sorted list is not cleared, only entries written in the current round are read.
// ----------------------------------------------------------------------------
// Echo distance median filter, top level
// Converts echo widths to distances, keeps credible ones in a sorted list and
// gives the median once per round when most pings were good.
// ----------------------------------------------------------------------------
module echo_distance_median_filter_top
	import edmf_pkg::*;
#(
	parameter int MAX_SAMPLES = 9
) (
	input  logic                 clk,
	input  logic                 arst_n,
	// configuration write port
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_data,
	// ping channel
	input  logic                 in_valid,
	output logic                 in_ready,
	input  logic [WIDTH_W-1:0]   echo_width_us,
	// result channel
	output logic                 out_valid,
	input  logic                 out_ready,
	output logic                 reading_valid,
	output logic [DIST_W-1:0]    distance,
	output logic [CNT_W-1:0]     good_count
);

	localparam int IDX_W = (MAX_SAMPLES > 1) ? $clog2(MAX_SAMPLES) : 1;
	localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_SAMPLES);

	// Configuration registers
	logic [CNT_W-1:0]   sample_count_q;
	logic [DIST_W-1:0]  min_distance_q;
	logic [DIST_W-1:0]  max_distance_q;
	logic [WIDTH_W-1:0] timeout_us_q;

	// Round state
	logic [DIST_W-1:0]  sorted_q [MAX_SAMPLES];
	logic [CNT_W-1:0]   good_seen_q;
	logic [CNT_W-1:0]   pings_seen_q;

	// Input stage
	logic               v_s1;
	logic               good_s1;
	logic [DIST_W-1:0]  dist_s1;

	// Result register
	logic               out_valid_q;
	logic               reading_valid_q;
	logic [DIST_W-1:0]  distance_q;
	logic [CNT_W-1:0]   good_count_q;

	logic               in_fire;
	logic               adv;
	logic [PROD_W-1:0]  prod;
	logic [DIST_W-1:0]  dist_in;
	logic               good_in;
	logic               ins;
	logic [MAX_SAMPLES-1:0] gt;
	logic [MAX_SAMPLES-1:0] wr_en;
	logic [DIST_W-1:0]  sorted_nx [MAX_SAMPLES];
	logic [CNT_W-1:0]   good_nx;
	logic [CNT_W-1:0]   pings_nx;
	logic [CNT_W-1:0]   round_len;
	logic               round_end;
	logic               ok;
	logic [IDX_W-1:0]   med_idx;
	logic [CNT_W-1:0]   med_cnt;
	logic [CNT_W:0]     good_dbl;

	// Handshake: the input stage moves on whenever the result register is free
	assign adv      = v_s1 && (!out_valid_q || out_ready);
	assign in_ready = !v_s1 || adv;
	assign in_fire  = in_valid && in_ready;

	// Convert width to distance and classify on the way into the input stage
	assign prod    = PROD_W'(echo_width_us) * PROD_W'(DIST_MULT);
	assign dist_in = prod[DIST_SHIFT +: DIST_W];
	assign good_in = (echo_width_us != '0) && (echo_width_us <= timeout_us_q) &&
	                 (dist_in >= min_distance_q) && (dist_in <= max_distance_q);

	// Write configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sample_count_q <= RST_SAMPLE_COUNT;
			min_distance_q <= RST_MIN_DISTANCE;
			max_distance_q <= RST_MAX_DISTANCE;
			timeout_us_q   <= RST_TIMEOUT_US;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_SAMPLE_COUNT: sample_count_q <= cfg_data[CNT_W-1:0];
				REG_MIN_DISTANCE: min_distance_q <= cfg_data[DIST_W-1:0];
				REG_MAX_DISTANCE: max_distance_q <= cfg_data[DIST_W-1:0];
				REG_TIMEOUT_US:   timeout_us_q   <= cfg_data[WIDTH_W-1:0];
				default: ;
			endcase
		end
	end

	// Input stage valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (in_ready) begin
			v_s1 <= in_valid;
		end
	end

	// Input stage payload
	always_ff @(posedge clk) begin
		if (in_fire) begin
			good_s1 <= good_in;
			dist_s1 <= dist_in;
		end
	end

	// Parallel insertion: entries above the new value shift up one place
	assign ins = good_s1 && (good_seen_q < MAX_CNT);

	always_comb begin
		for (int i = 0; i < MAX_SAMPLES; i++) begin
			gt[i] = ins && (CNT_W'(i) < good_seen_q) && (sorted_q[i] > dist_s1);
		end
		for (int i = 0; i < MAX_SAMPLES; i++) begin
			wr_en[i] = ins && (CNT_W'(i) <= good_seen_q);
			if (i > 0 && gt[(i > 0) ? i - 1 : 0]) begin
				sorted_nx[i] = sorted_q[(i > 0) ? i - 1 : 0];
			end else if (gt[i] || (CNT_W'(i) == good_seen_q)) begin
				sorted_nx[i] = dist_s1;
			end else begin
				sorted_nx[i] = sorted_q[i];
			end
		end
	end

	// Round bookkeeping and result
	assign good_nx  = good_seen_q + CNT_W'(ins);
	assign pings_nx = pings_seen_q + CNT_W'(1);

	always_comb begin
		if (sample_count_q == '0) begin
			round_len = CNT_W'(1);
		end else if (sample_count_q > MAX_CNT) begin
			round_len = MAX_CNT;
		end else begin
			round_len = sample_count_q;
		end
	end

	assign round_end = pings_nx >= round_len;
	assign good_dbl  = {good_nx, 1'b0};
	assign ok        = (good_nx != '0) && (good_dbl > {1'b0, pings_nx});
	assign med_cnt   = good_nx >> 1;
	assign med_idx   = med_cnt[IDX_W-1:0];

	// Update the sorted list
	always_ff @(posedge clk) begin
		if (adv) begin
			for (int i = 0; i < MAX_SAMPLES; i++) begin
				if (wr_en[i]) begin
					sorted_q[i] <= sorted_nx[i];
				end
			end
		end
	end

	// Advance the round counters, clear them at the end of a round
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			good_seen_q  <= '0;
			pings_seen_q <= '0;
		end else if (adv) begin
			if (round_end) begin
				good_seen_q  <= '0;
				pings_seen_q <= '0;
			end else begin
				good_seen_q  <= good_nx;
				pings_seen_q <= pings_nx;
			end
		end
	end

	// Result register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv && round_end) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// Result register payload
	always_ff @(posedge clk) begin
		if (adv && round_end) begin
			reading_valid_q <= ok;
			distance_q      <= ok ? sorted_nx[med_idx] : '0;
			good_count_q    <= good_nx;
		end
	end

	assign out_valid     = out_valid_q;
	assign reading_valid = reading_valid_q;
	assign distance      = distance_q;
	assign good_count    = good_count_q;

`ifndef SYNTHESIS
	// Good pings never outnumber pings in a round
	a_good_le_pings: assert property (@(posedge clk) disable iff (!arst_n)
		good_seen_q <= pings_seen_q)
		else $error("good count exceeds ping count");

	// A round end clears the counters
	a_round_clear: assert property (@(posedge clk) disable iff (!arst_n)
		adv && round_end |=> (pings_seen_q == '0) && (good_seen_q == '0))
		else $error("round counters not cleared");

	// A valid reading has at least one good ping
	a_valid_has_good: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && reading_valid_q |-> good_count_q != '0)
		else $error("valid reading without good pings");

	// An invalid reading reports zero distance
	a_invalid_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && !reading_valid_q |-> distance_q == '0)
		else $error("invalid reading with nonzero distance");
`endif

endmodule
